// ===== rtl/tnss_pkg.sv =====
// Package for the top-N score selector: word types, list entry type, fixed widths.
// No dependencies; used by every module in rtl/.
`default_nettype none

package tnss_pkg;

    // Fixed field widths
    localparam int SCORE_W = 32;
    localparam int POS_W   = 6;
    localparam int CW_W    = 4;

    // Reset value of the count_wanted register
    localparam logic [CW_W-1:0] CW_RESET = 4'd5;

    // One input word
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] best_score;
        logic                      last_of_run;
    } out_word_t;

    // One kept list entry
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/top_n_score_selector_unit.sv =====
// Top level of the streaming top-N score selector: a chain of tnss_cell slots
// holding the sorted list and a tnss_out_buf that sends the results. Uses tnss_pkg.
//
//   port group   dir   payload              notes
//   s_*          in    tnss_pkg::in_word_t  one vector element per word
//   m_*          out   tnss_pkg::out_word_t one reported entry per word
//   cfg_*        in    count_wanted [3:0]   always ready
//
// One element is taken per cycle; each slot compares and shifts as it is taken.
// Results start the cycle after the last element, one per cycle while m_ready is high.
// A last element waits in s_ready low until the previous vector's results are sent.
// Output stalls do not block non-last elements. Reset is synchronous (aresetn low);
// it empties the list at once, no clearing pass.
`default_nettype none

module top_n_score_selector_unit #(
    parameter int TOP_N   = 8,
    parameter int MAX_LEN = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tnss_pkg::in_word_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tnss_pkg::out_word_t                m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tnss_pkg::CW_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(TOP_N + 1);
    localparam int EC_W  = $clog2(MAX_LEN + 1);

    logic [tnss_pkg::CW_W-1:0] cw_reg;
    logic [CNT_W-1:0]          kc_reg;
    logic [CNT_W-1:0]          kc_next;
    logic [EC_W-1:0]           ec_reg;
    logic [EC_W-1:0]           ec_next;
    logic [CNT_W-1:0]          want;
    logic [CNT_W-1:0]          emit_cnt;
    logic                      accept;
    logic                      accept_last;
    logic                      ins;
    logic                      buf_idle;
    tnss_pkg::entry_t          new_entry;
    tnss_pkg::entry_t          cell_entry [TOP_N];
    tnss_pkg::entry_t          cell_next  [TOP_N];
    logic [TOP_N-1:0]          cell_take;
    logic [TOP_N-1:0]          cell_valid;

    // Handshakes
    assign cfg_ready   = 1'b1;
    assign s_ready     = !s_data.last || buf_idle;
    assign accept      = s_valid && s_ready;
    assign accept_last = accept && s_data.last;
    assign ins         = accept && (ec_reg < EC_W'(MAX_LEN));

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= tnss_pkg::CW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cw_reg <= cfg_data;
        end
    end

    // Element counter, saturating at MAX_LEN
    always_comb begin
        ec_next = ec_reg;
        if (accept_last) begin
            ec_next = '0;
        end else if (ins) begin
            ec_next = ec_reg + EC_W'(1);
        end
    end

    // Kept count after this word's insertion
    always_comb begin
        kc_next = kc_reg;
        if (ins && int'(kc_reg) < TOP_N) begin
            kc_next = kc_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ec_reg <= '0;
            kc_reg <= '0;
        end else begin
            ec_reg <= ec_next;
            kc_reg <= accept_last ? '0 : kc_next;
        end
    end

    // Clamp count_wanted to 1..TOP_N, then limit to what is kept
    always_comb begin
        if (cw_reg == '0) begin
            want = CNT_W'(1);
        end else if (int'(cw_reg) > TOP_N) begin
            want = CNT_W'(TOP_N);
        end else begin
            want = CNT_W'(cw_reg);
        end
        emit_cnt = (kc_next < want) ? kc_next : want;
    end

    assign new_entry.position = tnss_pkg::POS_W'(ec_reg);
    assign new_entry.score    = s_data.score;

    // Chain of list slots, best score in slot 0
    for (genvar i = 0; i < TOP_N; i++) begin : g_cell
        if (i == 0) begin : g_head
            tnss_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ins        (ins),
                .clr        (accept_last),
                .new_entry  (new_entry),
                .prev_take  (1'b0),
                .prev_valid (1'b0),
                .prev_entry ('0),
                .take       (cell_take[i]),
                .valid      (cell_valid[i]),
                .entry      (cell_entry[i]),
                .entry_next (cell_next[i])
            );
        end else begin : g_body
            tnss_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ins        (ins),
                .clr        (accept_last),
                .new_entry  (new_entry),
                .prev_take  (cell_take[i-1]),
                .prev_valid (cell_valid[i-1]),
                .prev_entry (cell_entry[i-1]),
                .take       (cell_take[i]),
                .valid      (cell_valid[i]),
                .entry      (cell_entry[i]),
                .entry_next (cell_next[i])
            );
        end
    end

    // Result buffer, loaded with the updated list on the last element
    tnss_out_buf #(
        .TOP_N (TOP_N),
        .CNT_W (CNT_W)
    ) u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept_last),
        .load_cnt     (emit_cnt),
        .load_entries (cell_next),
        .idle         (buf_idle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // Valid slots always form a contiguous run from slot 0
    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & (cell_valid + TOP_N'(1))) == '0)
        else $error("list slots not contiguous");

    // Kept count matches the number of valid slots
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(kc_reg))
        else $error("kept count out of step with slots");

    // A last element always produces results next cycle and empties the list
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_last |=> m_valid && (kc_reg == '0) && (ec_reg == '0))
        else $error("last element did not start results");

endmodule

`default_nettype wire

// ===== rtl/tnss_cell.sv =====
// One slot of the sorted top-N list; compares the incoming score against its own
// and either keeps, takes the new entry, or takes its upper neighbor's entry. Uses tnss_pkg.
`default_nettype none

module tnss_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ins,         // insert new_entry this cycle
    input  wire logic            clr,         // vector done, empty the slot
    input  wire tnss_pkg::entry_t new_entry,
    input  wire logic            prev_take,   // upper neighbor takes a new value
    input  wire logic            prev_valid,
    input  wire tnss_pkg::entry_t prev_entry,
    output logic                 take,
    output logic                 valid,
    output tnss_pkg::entry_t     entry,
    output tnss_pkg::entry_t     entry_next
);

    logic             valid_reg;
    logic             valid_next;
    tnss_pkg::entry_t entry_reg;

    // Strictly greater wins, so an equal score stays behind the earlier one
    assign take = !valid_reg || (entry_reg.score < new_entry.score);

    // Slot update: shift down from neighbor, take new, or hold
    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ins) begin
            if (prev_take) begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end else if (take) begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= clr ? 1'b0 : valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/tnss_out_buf.sv =====
// Result buffer for the top-N selector: loads the finished list in parallel
// and shifts it out one word per handshake. Uses tnss_pkg.
`default_nettype none

module tnss_out_buf #(
    parameter int TOP_N = 8,
    parameter int CNT_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire logic [CNT_W-1:0] load_cnt,
    input  wire tnss_pkg::entry_t load_entries [TOP_N],
    output logic                  idle,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tnss_pkg::out_word_t   m_data
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    tnss_pkg::entry_t slot_reg [TOP_N];
    logic             pop;

    assign pop = m_valid && m_ready;

    // Words left to send
    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = load_cnt;
        end else if (pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Slots: parallel load, shift toward slot 0 on each pop
    for (genvar i = 0; i < TOP_N; i++) begin : g_slot
        always_ff @(posedge aclk) begin
            if (load) begin
                slot_reg[i] <= load_entries[i];
            end else if (pop) begin
                if (i + 1 < TOP_N) begin
                    slot_reg[i] <= slot_reg[(i + 1) % TOP_N];
                end
            end
        end
    end

    assign idle                = (cnt_reg == '0);
    assign m_valid             = !idle;
    assign m_data.position     = slot_reg[0].position;
    assign m_data.best_score   = slot_reg[0].score;
    assign m_data.last_of_run  = (cnt_reg == CNT_W'(1));

    // Count never exceeds the list depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) <= TOP_N)
        else $error("result count above list depth");

    // A load only happens into an empty buffer
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> idle)
        else $error("result buffer loaded while busy");

    // A stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(cnt_reg))
        else $error("result dropped under stall");

endmodule

`default_nettype wire

// ===== sim/top_n_score_selector_unit_tb.sv =====
// Testbench for top_n_score_selector_unit: streams score vectors through the block and
// checks every reported entry against a local ranking model. Needs tnss_pkg and the RTL.
module top_n_score_selector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_N   = 8;
    localparam int MAX_LEN = 64;

    // Queued input word plus a flag to hold it back until all results are in
    typedef struct packed {
        logic               hold;
        tnss_pkg::in_word_t w;
    } pending_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    tnss_pkg::in_word_t            s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    tnss_pkg::out_word_t           m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tnss_pkg::CW_W-1:0]     cfg_data  = '0;

    // Stimulus and expected results
    pending_t            score_q[$];
    tnss_pkg::out_word_t ranked_q[$];
    int                  words_queued = 0;
    int                  words_taken  = 0;
    int                  mismatches   = 0;

    // Ranking model state
    logic signed [tnss_pkg::SCORE_W-1:0] list_score[TOP_N];
    logic [tnss_pkg::POS_W-1:0]          list_pos[TOP_N];
    int                                  list_len = 0;
    int                                  elem_idx = 0;
    logic [tnss_pkg::CW_W-1:0]           count_wanted_m = tnss_pkg::CW_RESET;

    // Sender burst/gap and receiver stall state
    int burst_left = 1;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_cnt  = 0;
    int mode_left  = 0;

    top_n_score_selector_unit #(
        .TOP_N   (TOP_N),
        .MAX_LEN (MAX_LEN)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Insert one element into the sorted list; on last, queue the reported entries
    function automatic void take_element(tnss_pkg::in_word_t w);
        logic signed [tnss_pkg::SCORE_W-1:0] s;
        int                                  at;
        int                                  k;
        int                                  want;
        int                                  n;
        tnss_pkg::out_word_t                 r;
        s = w.score;
        if (elem_idx < MAX_LEN) begin
            at = 0;
            // equal scores keep the earlier position ahead
            while (at < list_len && list_score[at] >= s) at++;
            if (at < TOP_N) begin
                for (k = (list_len < TOP_N) ? list_len : TOP_N - 1; k > at; k--) begin
                    list_score[k] = list_score[k-1];
                    list_pos[k]   = list_pos[k-1];
                end
                list_score[at] = s;
                list_pos[at]   = tnss_pkg::POS_W'(elem_idx);
                if (list_len < TOP_N) list_len++;
            end
            elem_idx++;
        end
        if (!w.last) return;
        want = count_wanted_m;
        if (want < 1) want = 1;
        if (want > TOP_N) want = TOP_N;
        n = (list_len < want) ? list_len : want;
        for (k = 0; k < n; k++) begin
            r.position    = list_pos[k];
            r.best_score  = list_score[k];
            r.last_of_run = (k == n - 1);
            ranked_q = {ranked_q, r};
        end
        list_len = 0;
        elem_idx = 0;
    endfunction

    // Driver: bursts of words separated by random gaps
    always @(posedge aclk) begin : driver
        logic               nxt_valid;
        tnss_pkg::in_word_t nxt_data;
        pending_t           p;
        nxt_valid = s_valid;
        nxt_data  = s_data;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_element(s_data);
                words_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (score_q.size() > 0 &&
                             !(score_q[0].hold && ranked_q.size() > 0)) begin
                    p         = score_q.pop_front();
                    nxt_data  = p.w;
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        s_valid <= nxt_valid;
        s_data  <= nxt_data;
    end

    // Monitor: check each result word, then pick the next ready value
    always @(posedge aclk) begin : monitor
        tnss_pkg::out_word_t exp_w;
        logic                nxt_ready;
        if (aresetn && m_valid && m_ready) begin
            if (ranked_q.size() == 0) begin
                $error("result word with none expected: position %0d best_score %0d",
                       m_data.position, m_data.best_score);
                mismatches++;
            end else begin
                exp_w = ranked_q.pop_front();
                if (m_data.position !== exp_w.position) begin
                    $error("position: expected %0d, actual %0d",
                           exp_w.position, m_data.position);
                    mismatches++;
                end
                if (m_data.best_score !== exp_w.best_score) begin
                    $error("best_score: expected %0d, actual %0d",
                           exp_w.best_score, m_data.best_score);
                    mismatches++;
                end
                if (m_data.last_of_run !== exp_w.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           exp_w.last_of_run, m_data.last_of_run);
                    mismatches++;
                end
            end
        end
        // stall pattern switches between always ready, coin flips and long stalls
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(16, 80);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: nxt_ready = 1'b1;
            1: nxt_ready = 1'($urandom_range(0, 1));
            default: begin
                if (stall_cnt > 0) begin
                    stall_cnt--;
                    nxt_ready = 1'b0;
                end else begin
                    stall_cnt = $urandom_range(1, 12);
                    nxt_ready = 1'b1;
                end
            end
        endcase
        m_ready <= nxt_ready;
    end

    task automatic queue_word(input logic signed [tnss_pkg::SCORE_W-1:0] sc,
                              input logic lst, input logic hold);
        pending_t p;
        p.hold    = hold;
        p.w.score = sc;
        p.w.last  = lst;
        score_q = {score_q, p};
        words_queued++;
    endtask

    // Scores lean toward extremes and a small set of values so ties are common
    function automatic logic signed [tnss_pkg::SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return ($signed($urandom_range(0, 4)) - 2) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_vector(input int len, input logic hold);
        for (int i = 0; i < len; i++) queue_word(pick_score(), i == len - 1, hold && i == 0);
    endtask

    // Wait until every word is taken and every result has arrived, then let the block settle
    task automatic wait_idle();
        do @(posedge aclk); while (!(words_taken == words_queued && ranked_q.size() == 0));
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_count(input logic [tnss_pkg::CW_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        count_wanted_m = v;
        cfg_valid <= 1'b0;
    endtask

    // Limit on the whole run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : main
        int total;
        int ph;
        int p;
        int len;
        logic [tnss_pkg::CW_W-1:0] cw;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset count: single element, short vector, ties and extremes
        queue_word(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b1);
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h0001_0000, 1'b0, 1'b0);
        queue_word(32'h0001_0000, 1'b0, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_word(32'hFFFF_0000, 1'b0, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'h0001_0000, 1'b0, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        queue_word(32'h0001_0000, 1'b1, 1'b0);
        wait_idle();

        // count zero reports one entry; tie at the top goes to the earlier position
        write_count(4'd0);
        queue_word(32'h0009_0000, 1'b0, 1'b0);
        queue_word(32'h0009_0000, 1'b0, 1'b0);
        queue_word(32'hFFFD_0000, 1'b0, 1'b0);
        queue_word(32'h0002_0000, 1'b1, 1'b0);
        wait_idle();

        // count above the list size, short vector
        write_count(4'd15);
        queue_word(32'h0000_0001, 1'b0, 1'b1);
        queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_word(32'h5555_5555, 1'b0, 1'b0);
        queue_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        queue_word(32'h0000_0001, 1'b0, 1'b0);
        queue_word(32'h8000_0001, 1'b1, 1'b0);
        wait_idle();

        // Random phases, each with its own count setting
        total = 0;
        p     = 0;
        while (total < 80) begin
            case (p)
                0:       cw = 4'd8;
                1:       cw = 4'd9;
                2:       cw = 4'd1;
                3:       cw = 4'd3;
                default: cw = tnss_pkg::CW_W'($urandom_range(0, 15));
            endcase
            write_count(cw);
            ph = 0;
            if (p == 1) begin
                // overlong vector: high positions near the cut, dropped words past it
                for (int i = 0; i < 67; i++) begin
                    if (i >= MAX_LEN)
                        queue_word(32'h7FFF_FFFF, i == 66, 1'b0);
                    else if (i >= 60)
                        queue_word(32'h7FFF_0000 + i, 1'b0, 1'b0);
                    else
                        queue_word(pick_score(), 1'b0, i == 0);
                end
                ph += 67;
            end
            while (ph < 18 && total + ph < 80) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                queue_vector(len, $urandom_range(0, 3) == 0);
                ph += len;
            end
            total += ph;
            p++;
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && ranked_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tnss_pkg.sv
rtl/tnss_cell.sv
rtl/tnss_out_buf.sv
rtl/top_n_score_selector_unit.sv
sim/top_n_score_selector_unit_tb.sv
